FILE: src/apre_pkg.sv
`timescale 1ns / 1ps
// shared types, request codes and control structs of the alpha plane rectangle engine
package apre_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam logic [9:0] PLANE_WIDTH_RESET = 10'd512;

  localparam logic [2:0] OP_GET  = 3'd0;
  localparam logic [2:0] OP_FILL = 3'd1;
  localparam logic [2:0] OP_LCUT = 3'd2;
  localparam logic [2:0] OP_UCUT = 3'd3;
  localparam logic [2:0] OP_COPY = 3'd4;

  typedef struct packed {
    logic [2:0] req_type;
    logic [8:0] x;
    logic [8:0] y;
    logic [9:0] rect_width;
    logic [9:0] rect_height;
    logic [8:0] dest_x;
    logic [8:0] dest_y;
    logic [7:0] threshold;
    logic [7:0] level;
  } req_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       status;
  } res_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic check;
    logic start;
    logic mul_s;
    logic mul_d;
    logic addr;
    logic dir;
    logic rd;
    logic wr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic skip;
    logic last_col;
    logic last_row;
  } stat_t;

endpackage

FILE: src/alpha_plane_rect_engine_core.sv
`timescale 1ns / 1ps
// top level of the alpha plane rectangle engine
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------
//  request   | start, busy             | req (req_t)
//  result    | done (one-cycle strobe) | res (res_t)
//  config    | cfg_we                  | cfg_data (plane width, 10 bits)
//
// a request walks h rows of w pixels from accept to done; every pixel is one memory read,
// then one write on the plane memory's single port pair, with no write for get pixel or
// for a cut pixel outside its threshold. get pixel walks one pixel; rejected or empty requests skip the walk.
// after reset a clearing pass zeroes all MAX_WIDTH * MAX_HEIGHT pixels of the plane
// (262144 by default), with busy high; configuration writes are taken throughout.
// busy stays high until the result strobe; the receiver cannot stall done.
module alpha_plane_rect_engine_core import apre_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  req_t       req,
  output logic       busy,
  input  logic       cfg_we,
  input  logic [9:0] cfg_data,
  output logic       done,
  output res_t       res
);

  cmd_t  cmd;
  stat_t stat;

  apre_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  apre_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .stat     (stat),
    .res      (res)
  );

endmodule

FILE: src/apre_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module apre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/apre_ctrl.sv
`timescale 1ns / 1ps
// controller state machine: clearing pass, bounds check, row and pixel walk
module apre_ctrl import apre_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_CHECK = 11'b000_0000_0100,
    S_START = 11'b000_0000_1000,
    S_MUL_S = 11'b000_0001_0000,
    S_MUL_D = 11'b000_0010_0000,
    S_ADDR  = 11'b000_0100_0000,
    S_DIR   = 11'b000_1000_0000,
    S_RD    = 11'b001_0000_0000,
    S_WR    = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = stat.skip ? S_DONE : S_MUL_S;
      end
      S_MUL_S: begin
        cmd.mul_s  = 1'b1;
        state_next = S_MUL_D;
      end
      S_MUL_D: begin
        cmd.mul_d  = 1'b1;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = S_DIR;
      end
      S_DIR: begin
        cmd.dir    = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (!stat.last_col) begin
          state_next = S_RD;
        end else if (stat.last_row) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MUL_S;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

FILE: src/apre_datapath.sv
`timescale 1ns / 1ps
// datapath: pitch register, request registers, address generation and plane memory
module apre_datapath import apre_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  req_t       req,
  input  logic       cfg_we,
  input  logic [9:0] cfg_data,
  output stat_t      stat,
  output res_t       res
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int PW    = $clog2(MAX_WIDTH + 1);
  localparam int MW    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW    = ($clog2(MW + 1) > 11) ? $clog2(MW + 1) : 11;
  localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
  localparam logic [CW-1:0] MAXH_C = CW'(MAX_HEIGHT);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

  // configuration
  logic [9:0]    plane_width;
  logic [PW-1:0] pitch_eff;

  // request registers
  logic [2:0]    op;
  logic [8:0]    x;
  logic [8:0]    y;
  logic [9:0]    w;
  logic [9:0]    h;
  logic [8:0]    dx;
  logic [8:0]    dy;
  logic [7:0]    thr;
  logic [7:0]    lv;
  logic [PW-1:0] pitch;

  // walk state
  logic          bad;
  logic          empty;
  logic          bu;
  logic          rev;
  logic [RW-1:0] src_row;
  logic [RW-1:0] dst_row;
  logic [9:0]    rows_left;
  logic [9:0]    cols_left;
  logic [AW-1:0] src_base;
  logic [AW-1:0] dst_base;
  logic [AW-1:0] src_addr;
  logic [AW-1:0] dst_addr;
  logic [AW-1:0] clr_cnt;
  logic [7:0]    pix;
  logic          status;

  // combinational
  logic          is_get;
  logic          is_copy;
  logic [CW-1:0] sum_xw;
  logic [CW-1:0] sum_yh;
  logic [CW-1:0] sum_dxw;
  logic [CW-1:0] sum_dyh;
  logic          in_src;
  logic          in_dst;
  logic          get_ok;
  logic          bad_next;
  logic [RW-1:0]    mul_row;
  logic [RW+PW-1:0] prod;
  logic [9:0]    wm1;
  logic [AW-1:0] wm1_a;
  logic [7:0]    rdata;
  logic          hit;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_width <= PLANE_WIDTH_RESET;
    end else if (cfg_we) begin
      plane_width <= cfg_data;
    end
  end

  // zero pitch acts as one, oversize pitch is clamped
  always_comb begin
    if (plane_width == 10'd0) begin
      pitch_eff = PW'(1);
    end else if (CW'(plane_width) > MAXW_C) begin
      pitch_eff = PW'(MAX_WIDTH);
    end else begin
      pitch_eff = PW'(plane_width);
    end
  end

  assign is_get  = (op == OP_GET);
  assign is_copy = (op == OP_COPY);

  assign sum_xw  = CW'(x) + CW'(w);
  assign sum_yh  = CW'(y) + CW'(h);
  assign sum_dxw = CW'(dx) + CW'(w);
  assign sum_dyh = CW'(dy) + CW'(h);
  assign in_src  = (sum_xw <= CW'(pitch)) && (sum_yh <= MAXH_C);
  assign in_dst  = (sum_dxw <= CW'(pitch)) && (sum_dyh <= MAXH_C);
  assign get_ok  = (CW'(x) < CW'(pitch)) && (CW'(y) < MAXH_C);

  always_comb begin
    unique case (op)
      OP_GET:                    bad_next = !get_ok;
      OP_FILL, OP_LCUT, OP_UCUT: bad_next = !in_src;
      OP_COPY:                   bad_next = !(in_src && in_dst);
      default:                   bad_next = 1'b1;
    endcase
  end

  // one shared row multiplier, source row first, then destination row
  assign mul_row = cmd.mul_d ? dst_row : src_row;
  assign prod    = {{PW{1'b0}}, mul_row} * {{RW{1'b0}}, pitch};

  assign wm1   = w - 10'd1;
  assign wm1_a = AW'(wm1);

  assign hit = (op == OP_FILL) || is_copy ||
               ((op == OP_LCUT) && (rdata <= thr)) ||
               ((op == OP_UCUT) && (rdata >= thr));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= req.req_type;
      x     <= req.x;
      y     <= req.y;
      w     <= req.rect_width;
      h     <= req.rect_height;
      dx    <= req.dest_x;
      dy    <= req.dest_y;
      thr   <= req.threshold;
      lv    <= req.level;
      pitch <= pitch_eff;
    end
    if (cmd.check) begin
      bad    <= bad_next;
      empty  <= !is_get && ((w == 10'd0) || (h == 10'd0));
      bu     <= is_copy && (CW'(y) <= CW'(dy)) && (CW'(dy) < sum_yh);
      status <= bad_next;
      pix    <= 8'd0;
      // get pixel walks a single pixel
      if (is_get) begin
        w <= 10'd1;
        h <= 10'd1;
      end
    end
    if (cmd.start) begin
      src_row   <= bu ? RW'(sum_yh - CW'(1)) : RW'(y);
      dst_row   <= bu ? RW'(sum_dyh - CW'(1)) : RW'(dy);
      rows_left <= h;
    end
    if (cmd.mul_s) begin
      src_base <= AW'(prod);
    end
    if (cmd.mul_d) begin
      dst_base <= AW'(prod);
    end
    if (cmd.addr) begin
      src_addr  <= src_base + AW'(x);
      dst_addr  <= dst_base + AW'(dx);
      cols_left <= w;
    end
    if (cmd.dir) begin
      // a copy row moves right to left when the destination lies at a higher address than the source
      if (is_copy && (dst_addr > src_addr)) begin
        rev      <= 1'b1;
        src_addr <= src_addr + wm1_a;
        dst_addr <= dst_addr + wm1_a;
      end else begin
        rev <= 1'b0;
      end
    end
    if (cmd.wr) begin
      if (is_get) pix <= rdata;
      src_addr  <= rev ? src_addr - AW'(1) : src_addr + AW'(1);
      dst_addr  <= rev ? dst_addr - AW'(1) : dst_addr + AW'(1);
      cols_left <= cols_left - 10'd1;
      if (cols_left == 10'd1) begin
        rows_left <= rows_left - 10'd1;
        src_row   <= bu ? src_row - RW'(1) : src_row + RW'(1);
        dst_row   <= bu ? dst_row - RW'(1) : dst_row + RW'(1);
      end
    end
  end

  assign ram_we    = cmd.clr || (cmd.wr && !is_get && hit);
  assign ram_waddr = cmd.clr ? clr_cnt : (is_copy ? dst_addr : src_addr);
  assign ram_wdata = cmd.clr ? 8'd0 : (is_copy ? rdata : lv);

  apre_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_plane (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (src_addr),
    .rdata (rdata)
  );

  assign stat.clr_last = (clr_cnt == LAST_A);
  assign stat.skip     = bad || empty;
  assign stat.last_col = (cols_left == 10'd1);
  assign stat.last_row = (rows_left == 10'd1);

  assign res.pixel_value = pix;
  assign res.status      = status;

endmodule

FILE: src/apre_checker.sv
`timescale 1ns / 1ps
// port-level checker of the alpha plane rectangle engine and its bind
module apre_checker import apre_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input req_t req,
  input logic busy,
  input logic done,
  input res_t res
);

  // an accepted request keeps the engine busy in the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("engine not busy after accepted request");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done strobe longer than one cycle");

  // unknown request types are rejected without touching the plane
  a_unknown_rejected: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.req_type > OP_COPY)) |-> ##3 (done && res.status))
    else $error("unknown request not rejected on time");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.status) |-> (res.pixel_value == 8'd0))
    else $error("rejected request returned nonzero pixel");

endmodule

bind alpha_plane_rect_engine_core apre_checker u_apre_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .req   (req),
  .busy  (busy),
  .done  (done),
  .res   (res)
);
